>>> rtl/ksd_pkg.sv
// ----------------------------------------------------------------------------
// Key sequence detector package
// Shared constants, payload and command types for the key sequence detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ksd_pkg;

   localparam int KSD_LOG_DEPTH    = 10;
   localparam int KSD_MAX_PATTERNS = 16;
   localparam int KSD_CODE_BITS    = 9;

   localparam int KSD_ADDR_BITS = 3;

   localparam logic [2:0] OP_LOG_KEY   = 3'd0;
   localparam logic [2:0] OP_CHECK     = 3'd1;
   localparam logic [2:0] OP_WRITE_ELT = 3'd2;
   localparam logic [2:0] OP_WRITE_HDR = 3'd3;
   localparam logic [2:0] OP_EMPTY_LOG = 3'd4;

   localparam logic REG_DEVELOPER_MODE = 1'b0;
   localparam logic REG_PATTERN_COUNT  = 1'b1;

   typedef struct packed {
      logic [2:0] operation;
      logic [8:0] key_code;
      logic [3:0] pattern_index;
      logic [3:0] element_index;
      logic [3:0] code_length;
      logic       dev_only;
   } req_type;

   typedef struct packed {
      logic       matched;
      logic [3:0] match_index;
   } rsp_type;

   typedef struct packed {
      logic log_push;
      logic log_clear;
      logic elem_we;
      logic hdr_we;
      logic rd_en;
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

>>> rtl/ksd_csr.sv
// ----------------------------------------------------------------------------
// Key sequence detector register file
// Holds the developer mode flag and the number of table sequences in use.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_csr
   import ksd_pkg::*;
#(
   parameter int MAX_PATTERNS = KSD_MAX_PATTERNS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [KSD_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output logic                          developer_mode,
   output logic [4:0]                    pattern_count
);

   logic       dev_mode_ff;
   logic       dev_mode_in;
   logic [4:0] count_ff;
   logic [4:0] count_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      dev_mode_in = dev_mode_ff;
      count_in    = count_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_DEVELOPER_MODE: begin
               dev_mode_in = pwdata[0];
            end
            REG_PATTERN_COUNT: begin
               if (32'(pwdata[4:0]) > 32'(MAX_PATTERNS)) begin
                  count_in = 5'(MAX_PATTERNS);
               end else begin
                  count_in = pwdata[4:0];
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_mode_ff <= 1'b0;
         count_ff    <= 5'd0;
      end else begin
         dev_mode_ff <= dev_mode_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_DEVELOPER_MODE: prdata = {31'd0, dev_mode_ff};
         REG_PATTERN_COUNT:  prdata = {27'd0, count_ff};
         default:            prdata = 32'd0;
      endcase
   end

   assign developer_mode = dev_mode_ff;
   assign pattern_count  = count_ff;

endmodule

`default_nettype wire

>>> rtl/ksd_dp.sv
// ----------------------------------------------------------------------------
// Key sequence detector datapath
// Key log shift register, sequence table memories and the sequence compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_dp
   import ksd_pkg::*;
#(
   parameter int LOG_DEPTH    = KSD_LOG_DEPTH,
   parameter int MAX_PATTERNS = KSD_MAX_PATTERNS,
   parameter int CODE_BITS    = KSD_CODE_BITS,
   localparam int AW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   input  wire req_type       req,
   input  wire logic          developer_mode,
   input  wire logic [AW-1:0] rd_addr,
   output logic               hit,
   output logic [AW-1:0]      hit_addr
);

   localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int FW = $clog2(LOG_DEPTH + 1);

   logic [CODE_BITS-1:0]                 log_ff [LOG_DEPTH];
   logic [FW-1:0]                        fill_ff;
   logic [FW-1:0]                        fill_in;
   logic [LOG_DEPTH-1:0][CODE_BITS-1:0]  code_mem_ff [MAX_PATTERNS];
   logic [4:0]                           hdr_mem_ff [MAX_PATTERNS];
   logic [LOG_DEPTH-1:0][CODE_BITS-1:0]  row_ff;
   logic [3:0]                           len_ff;
   logic                                 restr_ff;
   logic [AW-1:0]                        addr_ff;

   logic [CODE_BITS+8:0] code_ext;
   logic [CODE_BITS-1:0] code;
   logic [AW+3:0]        pidx_ext;
   logic [AW-1:0]        pidx;
   logic [LW+3:0]        eidx_ext;
   logic [LW-1:0]        eidx;
   logic                 pidx_ok;
   logic                 eidx_ok;

   assign code_ext = {{CODE_BITS{1'b0}}, req.key_code};
   assign code     = code_ext[CODE_BITS-1:0];
   assign pidx_ext = {{AW{1'b0}}, req.pattern_index};
   assign pidx     = pidx_ext[AW-1:0];
   assign eidx_ext = {{LW{1'b0}}, req.element_index};
   assign eidx     = eidx_ext[LW-1:0];
   assign pidx_ok  = 32'(req.pattern_index) < 32'(MAX_PATTERNS);
   assign eidx_ok  = 32'(req.element_index) < 32'(LOG_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.log_push) begin
         log_ff[0] <= code;
         for (int i = 1; i < LOG_DEPTH; i++) begin
            log_ff[i] <= log_ff[i-1];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.log_clear) begin
         fill_in = '0;
      end else if (cmd.log_push && (32'(fill_ff) < 32'(LOG_DEPTH))) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.elem_we && pidx_ok && eidx_ok) begin
         code_mem_ff[pidx][eidx] <= code;
      end
      if (cmd.hdr_we && pidx_ok) begin
         hdr_mem_ff[pidx] <= {req.dev_only, req.code_length};
      end
      if (cmd.rd_en) begin
         row_ff                <= code_mem_ff[rd_addr];
         {restr_ff, len_ff}    <= hdr_mem_ff[rd_addr];
         addr_ff               <= rd_addr;
      end
   end

   always_comb begin
      int   j;
      logic all_eq;
      all_eq = 1'b1;
      j      = 0;
      for (int k = 0; k < LOG_DEPTH; k++) begin
         j = int'(len_ff) - 1 - k;
         if (k < int'(len_ff)) begin
            if (row_ff[k] != log_ff[j[LW-1:0]]) begin
               all_eq = 1'b0;
            end
         end
      end
      hit = all_eq && (32'(len_ff) <= 32'(fill_ff)) && (!restr_ff || developer_mode);
   end

   assign hit_addr = addr_ff;

endmodule

`default_nettype wire

>>> rtl/ksd_ctrl.sv
// ----------------------------------------------------------------------------
// Key sequence detector controller
// Decodes operations, steps through the sequence table and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_ctrl
   import ksd_pkg::*;
#(
   parameter int MAX_PATTERNS = KSD_MAX_PATTERNS,
   localparam int AW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [2:0]    operation,
   input  wire logic [4:0]    pattern_count,
   input  wire logic          hit,
   input  wire logic [AW-1:0] hit_addr,
   output logic               busy,
   output cmd_type            cmd,
   output logic [AW-1:0]      rd_addr,
   output logic               rsp_strobe,
   output rsp_type            rsp
);

   localparam int PW = $clog2(MAX_PATTERNS + 1);

   state_type     state_ff;
   state_type     state_in;
   logic [PW-1:0] ptr_ff;
   logic [PW-1:0] ptr_in;
   logic          pending_ff;
   logic          strobe_ff;
   logic          strobe_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic          accept;
   logic          more;
   logic          hit_valid;
   logic          scan_done;
   logic [AW+3:0] idx_ext;

   assign accept    = start && (state_ff == ST_IDLE);
   assign more      = 32'(ptr_ff) < 32'(pattern_count);
   assign hit_valid = (state_ff == ST_SCAN) && pending_ff && hit;
   assign scan_done = (state_ff == ST_SCAN) && !hit_valid && !more;
   assign idx_ext   = {4'd0, hit_addr};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (operation == OP_CHECK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit_valid || scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      ptr_in        = ptr_ff;
      strobe_in     = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            ptr_in        = '0;
            cmd.log_push  = accept && (operation == OP_LOG_KEY);
            cmd.log_clear = accept && (operation == OP_EMPTY_LOG);
            cmd.elem_we   = accept && (operation == OP_WRITE_ELT);
            cmd.hdr_we    = accept && (operation == OP_WRITE_HDR);
            strobe_in     = accept && (operation != OP_CHECK);
         end
         ST_SCAN: begin
            cmd.rd_en     = !hit_valid && more;
            cmd.log_clear = hit_valid;
            if (cmd.rd_en) begin
               ptr_in = ptr_ff + 1'b1;
            end
            strobe_in          = hit_valid || scan_done;
            rsp_in.matched     = hit_valid;
            rsp_in.match_index = hit_valid ? idx_ext[3:0] : 4'd0;
         end
         default: begin
            ptr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ptr_ff     <= '0;
         pending_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         pending_ff <= cmd.rd_en;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rd_addr    = ptr_ff[AW-1:0];
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   a_check_enters_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && (operation == OP_CHECK)) |=> (state_ff == ST_SCAN))
      else $error("check item did not start a table scan");

   a_hit_reports: assert property (@(posedge clock) disable iff (reset)
      hit_valid |=> (strobe_ff && rsp_ff.matched && (state_ff == ST_IDLE)))
      else $error("match was not reported on the next cycle");

   a_matched_strobed: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.matched |-> strobe_ff)
      else $error("matched result without strobe");

   a_writes_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.log_push || cmd.elem_we || cmd.hdr_we) |-> (state_ff == ST_IDLE))
      else $error("log or table write during a scan");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(ptr_ff) <= 32'(pattern_count)))
      else $error("scan pointer ran past the sequence count");

endmodule

`default_nettype wire

>>> rtl/key_sequence_detector_core.sv
// ----------------------------------------------------------------------------
// Key sequence detector core
// Key log, sequence table and first-match search with an APB register port.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Log, empty and table
// write items leave busy low, so one may follow every cycle, and each gives
// its result on rsp_strobe in the cycle after it is taken. A check item holds
// busy high while it scans the table sequences in use, stopping early when a
// sequence matches; the sequence table memory is read one sequence per cycle
// and each row is compared on the cycle after its read, and the result
// follows on rsp_strobe in the cycle after the scan ends. Results are shown for
// exactly one cycle and cannot be held off.
`default_nettype none

module key_sequence_detector_core
   import ksd_pkg::*;
#(
   parameter int LOG_DEPTH    = KSD_LOG_DEPTH,
   parameter int MAX_PATTERNS = KSD_MAX_PATTERNS,
   parameter int CODE_BITS    = KSD_CODE_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_type                  req_payload,
   output logic                          rsp_strobe,
   output rsp_type                       rsp_payload,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [KSD_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int AW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

   logic          developer_mode;
   logic [4:0]    pattern_count;
   cmd_type       cmd;
   logic [AW-1:0] rd_addr;
   logic          hit;
   logic [AW-1:0] hit_addr;

   ksd_csr #(
      .MAX_PATTERNS(MAX_PATTERNS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .developer_mode(developer_mode),
      .pattern_count (pattern_count)
   );

   ksd_ctrl #(
      .MAX_PATTERNS(MAX_PATTERNS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .operation    (req_payload.operation),
      .pattern_count(pattern_count),
      .hit          (hit),
      .hit_addr     (hit_addr),
      .busy         (busy),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .rsp_strobe   (rsp_strobe),
      .rsp          (rsp_payload)
   );

   ksd_dp #(
      .LOG_DEPTH   (LOG_DEPTH),
      .MAX_PATTERNS(MAX_PATTERNS),
      .CODE_BITS   (CODE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req           (req_payload),
      .developer_mode(developer_mode),
      .rd_addr       (rd_addr),
      .hit           (hit),
      .hit_addr      (hit_addr)
   );

endmodule

`default_nettype wire

>>> test/tb_key_sequence_detector_core.sv
// ----------------------------------------------------------------------------
// Key sequence detector core testbench
// Fills the sequence table, runs a short list of directed items and then
// mostly well-formed key sequences followed by a check, mixed with random
// items. Several register settings are used. Every result is compared with
// a model of the log, the table and the first-match search.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_key_sequence_detector_core;
   import ksd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 100;
   localparam int NUM_PHASES  = 8;
   localparam int QUIET_PHASE = 3;

   class ksd_match_scoreboard;
      bit          dev_mode;
      int unsigned pat_count;
      logic [8:0]  key_log [KSD_LOG_DEPTH];
      int unsigned log_fill;
      logic [8:0]  seq_codes [KSD_MAX_PATTERNS][KSD_LOG_DEPTH];
      logic [3:0]  seq_len [KSD_MAX_PATTERNS];
      bit          seq_restricted [KSD_MAX_PATTERNS];
      rsp_type     expected_q [$];
      int unsigned failures;

      function new();
         dev_mode  = 1'b0;
         pat_count = 0;
         log_fill  = 0;
         failures  = 0;
         foreach (key_log[i]) key_log[i] = '0;
         foreach (seq_len[i]) begin
            seq_len[i] = '0;
            seq_restricted[i] = 1'b0;
            for (int k = 0; k < KSD_LOG_DEPTH; k++) seq_codes[i][k] = '0;
         end
      endfunction

      function void write_register(logic [KSD_ADDR_BITS-1:0] addr, logic [31:0] data);
         if (addr == {REG_DEVELOPER_MODE, 2'b00}) begin
            dev_mode = data[0];
         end else if (addr == {REG_PATTERN_COUNT, 2'b00}) begin
            pat_count = (data[4:0] > KSD_MAX_PATTERNS) ? KSD_MAX_PATTERNS : data[4:0];
         end
      endfunction

      function bit sequence_hits(int unsigned p);
         int unsigned len;
         int unsigned base;
         len = seq_len[p];
         if (len > log_fill) return 1'b0;
         base = log_fill - len;
         for (int k = 0; k < len; k++) begin
            if (seq_codes[p][k] != key_log[base + k]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_item(req_type r);
         rsp_type want;
         want = '0;
         case (r.operation)
            OP_LOG_KEY: begin
               if (log_fill < KSD_LOG_DEPTH) begin
                  key_log[log_fill] = r.key_code;
                  log_fill++;
               end else begin
                  for (int i = 0; i < KSD_LOG_DEPTH - 1; i++) key_log[i] = key_log[i + 1];
                  key_log[KSD_LOG_DEPTH - 1] = r.key_code;
               end
            end
            OP_CHECK: begin
               for (int unsigned p = 0; p < pat_count; p++) begin
                  if (seq_restricted[p] && !dev_mode) continue;
                  if (sequence_hits(p)) begin
                     want.matched = 1'b1;
                     want.match_index = p[3:0];
                     log_fill = 0;
                     break;
                  end
               end
            end
            OP_WRITE_ELT: begin
               if (r.element_index < KSD_LOG_DEPTH)
                  seq_codes[r.pattern_index][r.element_index] = r.key_code;
            end
            OP_WRITE_HDR: begin
               seq_len[r.pattern_index] = r.code_length;
               seq_restricted[r.pattern_index] = r.dev_only;
            end
            OP_EMPTY_LOG: log_fill = 0;
            default: ;
         endcase
         expected_q.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result with no item outstanding: matched %0d match_index %0d",
                   got.matched, got.match_index);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got.matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, got.matched);
            failures++;
         end
         if (got.match_index !== want.match_index) begin
            $error("match_index: expected %0d, actual %0d", want.match_index, got.match_index);
            failures++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   req_type                  req_payload;
   logic                     rsp_strobe;
   rsp_type                  rsp_payload;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [KSD_ADDR_BITS-1:0] paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   ksd_match_scoreboard board = new();
   bit          idle_enabled = 1'b1;
   int unsigned sent_items   = 0;
   int unsigned cycles       = 0;

   key_sequence_detector_core uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("key_sequence_detector_core test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_result(rsp_payload);
         if (start && !busy) board.note_item(req_payload);
         if (psel && penable && pwrite && pready) board.write_register(paddr, pwdata);
      end
   end

   function automatic logic [8:0] random_code();
      if ($urandom_range(0, 1) == 0)
         return board.seq_codes[$urandom_range(0, KSD_MAX_PATTERNS - 1)]
                               [$urandom_range(0, KSD_LOG_DEPTH - 1)];
      return 9'($urandom);
   endfunction

   function automatic req_type shaped(logic [2:0] op, logic [8:0] code);
      req_type r;
      r = req_type'($urandom);
      r.operation = op;
      r.key_code = code;
      return r;
   endfunction

   function automatic req_type noise_item();
      req_type     r;
      int unsigned pick;
      int unsigned shape;
      r = req_type'($urandom);
      pick = $urandom_range(0, 99);
      shape = $urandom_range(0, 99);
      if (pick < 40) begin
         r.operation = OP_LOG_KEY;
         r.key_code = random_code();
      end else if (pick < 55) begin
         r.operation = OP_CHECK;
      end else if (pick < 70) begin
         r.operation = OP_WRITE_ELT;
      end else if (pick < 78) begin
         r.operation = OP_WRITE_HDR;
         if (r.pattern_index >= 8 && shape < 10) r.code_length = 4'd0;
         else if (shape < 20) r.code_length = 4'($urandom_range(11, 15));
         else r.code_length = 4'($urandom_range(1, KSD_LOG_DEPTH));
      end else if (pick < 86) begin
         r.operation = OP_EMPTY_LOG;
      end else begin
         r.operation = 3'($urandom_range(5, 7));
      end
      return r;
   endfunction

   task automatic send_item(input req_type r);
      if (idle_enabled && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_items++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic log_pattern(input int unsigned p);
      int unsigned len;
      len = board.seq_len[p];
      for (int k = 0; k < len && k < KSD_LOG_DEPTH; k++)
         send_item(shaped(OP_LOG_KEY, board.seq_codes[p][k]));
   endtask

   task automatic sequence_then_check();
      int unsigned p;
      p = $urandom_range(0, board.pat_count - 1);
      repeat ($urandom_range(0, 3)) send_item(shaped(OP_LOG_KEY, random_code()));
      log_pattern(p);
      send_item(shaped(OP_CHECK, 9'($urandom)));
   endtask

   initial begin
      req_type     r;
      int unsigned target;
      bit          phase_dev [NUM_PHASES];
      int unsigned phase_cnt [NUM_PHASES];

      phase_dev = '{0, 1, 0, 1, 0, 1, 0, 1};
      phase_cnt = '{16, 16, 0, 31, 17, 5, 1, 16};
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(shaped(OP_LOG_KEY, 9'd0));
      send_item(shaped(OP_LOG_KEY, 9'h1FF));
      send_item(shaped(OP_CHECK, 9'h1FF));
      send_item(shaped(3'd5, 9'($urandom)));
      send_item(shaped(3'd6, 9'($urandom)));
      send_item(shaped(3'd7, 9'($urandom)));
      send_item(shaped(OP_EMPTY_LOG, 9'($urandom)));

      for (int p = 0; p < KSD_MAX_PATTERNS; p++) begin
         r = shaped(OP_WRITE_HDR, 9'($urandom));
         r.pattern_index = 4'(p);
         r.code_length = (p == 15) ? 4'd10 : 4'((p % 10) + 1);
         r.dev_only = (p % 4 == 3);
         send_item(r);
         for (int e = 0; e < KSD_LOG_DEPTH; e++) begin
            r = shaped(OP_WRITE_ELT, (e == 0) ? 9'h1FF : (e == 1) ? 9'd0 : 9'($urandom));
            r.pattern_index = 4'(p);
            r.element_index = 4'(e);
            send_item(r);
         end
      end

      wait_drained();
      csr_write(REG_DEVELOPER_MODE, 32'd0);
      csr_write(REG_PATTERN_COUNT, 32'd16);
      log_pattern(3);
      send_item(shaped(OP_CHECK, 9'($urandom)));
      r = shaped(OP_WRITE_ELT, 9'($urandom));
      r.pattern_index = 4'd5;
      r.element_index = 4'd12;
      send_item(r);
      r.element_index = 4'd15;
      send_item(r);
      r = shaped(OP_WRITE_HDR, 9'($urandom));
      r.pattern_index = 4'd14;
      r.code_length = 4'd15;
      r.dev_only = 1'b0;
      send_item(r);
      send_item(shaped(OP_LOG_KEY, 9'($urandom)));
      send_item(shaped(OP_LOG_KEY, 9'($urandom)));
      log_pattern(15);
      send_item(shaped(OP_CHECK, 9'($urandom)));
      r = shaped(OP_WRITE_HDR, 9'($urandom));
      r.pattern_index = 4'd15;
      r.code_length = 4'd0;
      r.dev_only = 1'b0;
      send_item(r);
      send_item(shaped(OP_CHECK, 9'($urandom)));
      r.code_length = 4'd10;
      send_item(r);
      wait_drained();
      csr_write(REG_DEVELOPER_MODE, 32'd1);
      log_pattern(3);
      send_item(shaped(OP_CHECK, 9'($urandom)));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         csr_write(REG_DEVELOPER_MODE, 32'(phase_dev[ph]));
         csr_write(REG_PATTERN_COUNT, 32'(phase_cnt[ph]));
         idle_enabled = (ph != QUIET_PHASE);
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) begin
            if (board.pat_count != 0 && $urandom_range(0, 99) < 50) sequence_then_check();
            else send_item(noise_item());
            if ($urandom_range(0, 99) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.expected_q.size() == 0) begin
         $display("key_sequence_detector_core test passed");
      end else begin
         $display("key_sequence_detector_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
rtl/ksd_pkg.sv
rtl/ksd_csr.sv
rtl/ksd_dp.sv
rtl/ksd_ctrl.sv
rtl/key_sequence_detector_core.sv
test/tb_key_sequence_detector_core.sv
